// ===== rtl/ssf_pkg.sv =====
// ssf_pkg: shared types and constants of the safety supervisor
// used by ssf_front, ssf_queue, ssf_back and the top level
package ssf_pkg;

  localparam int FaultW = 13;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CHECK   = 3'd1;
  localparam logic [2:0] CMD_ESTOP   = 3'd2;
  localparam logic [2:0] CMD_RECOVER = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_WDOG    = 3'd5;
  localparam logic [2:0] CMD_DROP    = 3'd6;
  localparam logic [2:0] CMD_LOCK    = 3'd7;

  localparam logic [2:0] ST_NOMINAL    = 3'd0;
  localparam logic [2:0] ST_DEGRADED   = 3'd1;
  localparam logic [2:0] ST_HOLD       = 3'd2;
  localparam logic [2:0] ST_RECOVERING = 3'd3;
  localparam logic [2:0] ST_FATAL      = 3'd4;
  localparam logic [2:0] ST_STARTUP    = 3'd5;

  localparam logic [12:0] F_IMU_TO  = 13'h0001;
  localparam logic [12:0] F_EMG_TO  = 13'h0002;
  localparam logic [12:0] F_IMU_NC  = 13'h0004;
  localparam logic [12:0] F_EMG_NC  = 13'h0008;
  localparam logic [12:0] F_IMU_BUS = 13'h0010;
  localparam logic [12:0] F_HEAP    = 13'h0020;
  localparam logic [12:0] F_STACK   = 13'h0040;
  localparam logic [12:0] F_QUEUE   = 13'h0080;
  localparam logic [12:0] F_RATE    = 13'h0100;
  localparam logic [12:0] F_WDT     = 13'h0200;
  localparam logic [12:0] F_USER    = 13'h0400;
  localparam logic [12:0] F_SERVO   = 13'h0800;
  localparam logic [12:0] F_INIT    = 13'h1000;

  localparam logic [12:0] CRIT_MASK = F_WDT | F_USER | F_INIT;
  localparam logic [12:0] HARD_MASK = F_WDT | F_IMU_BUS | F_INIT;
  localparam logic [12:0] SOFT_MASK = F_USER | F_RATE;
  localparam logic [12:0] DEGRADE_MASK = F_IMU_TO | F_EMG_TO | F_IMU_NC | F_EMG_NC | F_QUEUE
                                       | F_RATE | F_HEAP | F_STACK | F_IMU_BUS | F_SERVO;

  localparam logic [2:0] REG_WDOG   = 3'd0;
  localparam logic [2:0] REG_QLIMIT = 3'd1;
  localparam logic [2:0] REG_NAD    = 3'd2;
  localparam logic [2:0] REG_SRC    = 3'd3;
  localparam logic [2:0] REG_IMU    = 3'd4;
  localparam logic [2:0] REG_EMG    = 3'd5;
  localparam logic [2:0] REG_HEAP   = 3'd6;
  localparam logic [2:0] REG_SETTLE = 3'd7;

  typedef struct packed {
    logic        wdog_forces;
    logic [15:0] qlimit;
    logic        nad;
    logic [5:0]  src_mask;
    logic [15:0] imu_stale;
    logic [15:0] emg_stale;
    logic [31:0] heap_floor;
    logic [15:0] settle;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] time_ms;
    logic [3:0]  imu_flags;
    logic        imu_stale;   // sample age over limit, pre-computed
    logic [3:0]  emg_flags;
    logic        emg_stale;
    logic [31:0] free_heap;
    logic        heap_under;
    logic        cmd_is_estop;
    logic [1:0]  cmd_priority;
    logic [2:0]  cmd_source;
    logic [12:0] estop_cause;
    logic        lock_value;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  safety_state;
    logic [12:0] active_faults;
    logic [12:0] latched_faults;
    logic        imu_ok;
    logic        emg_ok;
    logic        stop_motion;
    logic        state_changed;
    logic [31:0] lowest_heap;
    logic [15:0] estop_total;
    logic [15:0] degraded_total;
    logic [15:0] recovery_total;
  } result_t;

endpackage

// ===== rtl/ssf_front.sv =====
// ssf_front: input register and classification of sensor age and heap level
// depends on ssf_pkg
module ssf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          command,
  input  logic [31:0]         time_ms,
  input  logic [3:0]          imu_flags,
  input  logic [31:0]         imu_sample_ms,
  input  logic [3:0]          emg_flags,
  input  logic [31:0]         emg_sample_ms,
  input  logic [31:0]         free_heap,
  input  logic                cmd_is_estop,
  input  logic [1:0]          cmd_priority,
  input  logic [2:0]          cmd_source,
  input  logic [12:0]         estop_cause,
  input  logic                lock_value,
  input  ssf_pkg::cfg_t       cfg,
  output logic                f_valid,
  input  logic                f_ready,
  output ssf_pkg::item_t      f_item
);
  logic           valid_r;
  ssf_pkg::item_t item_r, item_nxt;
  logic [31:0]    imu_age, emg_age;

  assign in_tready = !valid_r || f_ready;
  assign imu_age = time_ms - imu_sample_ms;
  assign emg_age = time_ms - emg_sample_ms;

  always_comb begin
    item_nxt.command      = command;
    item_nxt.time_ms      = time_ms;
    item_nxt.imu_flags    = imu_flags;
    item_nxt.imu_stale    = (imu_sample_ms != 32'd0) && (imu_age > {16'd0, cfg.imu_stale});
    item_nxt.emg_flags    = emg_flags;
    item_nxt.emg_stale    = (emg_sample_ms != 32'd0) && (emg_age > {16'd0, cfg.emg_stale});
    item_nxt.free_heap    = free_heap;
    item_nxt.heap_under   = free_heap < cfg.heap_floor;
    item_nxt.cmd_is_estop = cmd_is_estop;
    item_nxt.cmd_priority = cmd_priority;
    item_nxt.cmd_source   = cmd_source;
    item_nxt.estop_cause  = estop_cause;
    item_nxt.lock_value   = lock_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign f_valid = valid_r;
  assign f_item  = item_r;
endmodule

// ===== rtl/ssf_queue.sv =====
// ssf_queue: two-entry queue between front and back
// depends on ssf_pkg
module ssf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           w_valid,
  output logic           w_ready,
  input  ssf_pkg::item_t w_item,
  output logic           r_valid,
  input  logic           r_ready,
  output ssf_pkg::item_t r_item
);
  ssf_pkg::item_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign w_ready = cnt_r != 2'd2;
  assign r_valid = cnt_r != 2'd0;
  assign r_item  = mem_r[rp_r];
  assign push = w_valid && w_ready;
  assign pop  = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= w_item;
  end
endmodule

// ===== rtl/ssf_back.sv =====
// ssf_back: supervisor state, fault masks, counters and result register
// depends on ssf_pkg
module ssf_back #(
  parameter int DROP_WINDOW_MS = 5000,
  parameter int COUNTER_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ssf_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  ssf_pkg::item_t   q_item,
  output logic             o_valid,
  input  logic             o_ready,
  output ssf_pkg::result_t o_res
);
  localparam logic [COUNTER_BITS-1:0] CntMax = '1;
  localparam logic [31:0] WinMs = 32'(DROP_WINDOW_MS);

  logic [2:0]  mode_r, mode_nxt;
  logic [12:0] act_r, act_nxt, lat_r, lat_nxt;
  logic [31:0] prev_r, prev_nxt, rstart_r, rstart_nxt, win_r, win_nxt, heapmin_r, heapmin_nxt;
  logic [15:0] drops_r, drops_nxt;
  logic        wpend_r, wpend_nxt, lock_r, lock_nxt;
  logic [1:0]  health_r, health_nxt;
  logic [COUNTER_BITS-1:0] c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt;
  logic        ovalid_r;
  ssf_pkg::result_t res_r, res_nxt;
  logic        take;

  assign q_ready = !ovalid_r || o_ready;
  assign take = q_valid && q_ready;

  always_comb begin
    logic [2:0]  tgt;
    logic        acc, stop, chg, hw, ok;
    logic [12:0] m;
    ssf_pkg::item_t it;
    it = q_item;
    mode_nxt = mode_r; act_nxt = act_r; lat_nxt = lat_r; prev_nxt = prev_r;
    rstart_nxt = rstart_r; win_nxt = win_r; heapmin_nxt = heapmin_r;
    drops_nxt = drops_r; wpend_nxt = wpend_r; lock_nxt = lock_r; health_nxt = health_r;
    c0_nxt = c0_r; c1_nxt = c1_r; c2_nxt = c2_r;
    acc = 1'b0; stop = 1'b0; chg = 1'b0; tgt = mode_r; hw = 1'b0; ok = 1'b0; m = '0;
    unique case (it.command)
      ssf_pkg::CMD_TICK: begin
        // raise only sets latched when newly active
        if (wpend_r) begin
          wpend_nxt = 1'b0;
          if (!act_nxt[9]) lat_nxt = lat_nxt | ssf_pkg::F_WDT;
          act_nxt = act_nxt | ssf_pkg::F_WDT;
          if (cfg.wdog_forces && mode_nxt != ssf_pkg::ST_HOLD) begin
            mode_nxt = ssf_pkg::ST_HOLD;
            chg = 1'b1;
          end
          if (cfg.wdog_forces) stop = 1'b1;
        end
        // imu
        if (!it.imu_flags[0]) health_nxt[0] = 1'b1;
        else if (!it.imu_flags[1]) health_nxt[0] = 1'b0;
        else if (it.imu_stale || it.imu_flags[2]) begin
          health_nxt[0] = 1'b0;
          hw = it.imu_flags[2];
          if (hw && !act_nxt[4]) begin
            act_nxt = act_nxt | ssf_pkg::F_IMU_BUS; lat_nxt = lat_nxt | ssf_pkg::F_IMU_BUS;
          end
          if (it.imu_stale && !act_nxt[0]) begin
            act_nxt = act_nxt | ssf_pkg::F_IMU_TO; lat_nxt = lat_nxt | ssf_pkg::F_IMU_TO;
          end
        end else begin
          health_nxt[0] = 1'b1;
          act_nxt = act_nxt & ~(ssf_pkg::F_IMU_TO | ssf_pkg::F_IMU_BUS);
          if (it.imu_flags[3]) act_nxt = act_nxt & ~ssf_pkg::F_IMU_NC;
          else if (!act_nxt[2]) begin
            act_nxt = act_nxt | ssf_pkg::F_IMU_NC; lat_nxt = lat_nxt | ssf_pkg::F_IMU_NC;
          end
        end
        // emg
        if (!it.emg_flags[0]) health_nxt[1] = 1'b1;
        else if (!it.emg_flags[1]) health_nxt[1] = 1'b0;
        else if (it.emg_stale || it.emg_flags[2]) begin
          health_nxt[1] = 1'b0;
          if (!act_nxt[1]) begin
            act_nxt = act_nxt | ssf_pkg::F_EMG_TO; lat_nxt = lat_nxt | ssf_pkg::F_EMG_TO;
          end
        end else begin
          health_nxt[1] = 1'b1;
          act_nxt = act_nxt & ~ssf_pkg::F_EMG_TO;
          if (it.emg_flags[3]) act_nxt = act_nxt & ~ssf_pkg::F_EMG_NC;
          else if (!act_nxt[3]) begin
            act_nxt = act_nxt | ssf_pkg::F_EMG_NC; lat_nxt = lat_nxt | ssf_pkg::F_EMG_NC;
          end
        end
        // heap
        if (it.free_heap < heapmin_r) heapmin_nxt = it.free_heap;
        if (it.heap_under) begin
          if (!act_nxt[5]) begin
            act_nxt = act_nxt | ssf_pkg::F_HEAP; lat_nxt = lat_nxt | ssf_pkg::F_HEAP;
          end
        end else act_nxt = act_nxt & ~ssf_pkg::F_HEAP;
        // queue drop window
        if ((it.time_ms - win_r) > WinMs) begin
          if (drops_r > cfg.qlimit) begin
            if (!act_nxt[7]) begin
              act_nxt = act_nxt | ssf_pkg::F_QUEUE; lat_nxt = lat_nxt | ssf_pkg::F_QUEUE;
            end
          end else act_nxt = act_nxt & ~ssf_pkg::F_QUEUE;
          drops_nxt = '0;
          win_nxt = it.time_ms;
        end
        // target state, settle timer uses previous tick time
        m = act_nxt;
        if ((m & ssf_pkg::CRIT_MASK) != '0 && mode_nxt != ssf_pkg::ST_RECOVERING)
          tgt = ssf_pkg::ST_HOLD;
        else if (mode_nxt == ssf_pkg::ST_RECOVERING)
          tgt = (m == '0 && (prev_r - rstart_r) > {16'd0, cfg.settle})
              ? ssf_pkg::ST_NOMINAL : ssf_pkg::ST_RECOVERING;
        else if (mode_nxt == ssf_pkg::ST_HOLD) tgt = ssf_pkg::ST_HOLD;
        else if ((m & ssf_pkg::DEGRADE_MASK) != '0) tgt = ssf_pkg::ST_DEGRADED;
        else tgt = ssf_pkg::ST_NOMINAL;
        if (tgt != mode_nxt) begin
          if (tgt == ssf_pkg::ST_DEGRADED && c1_r != CntMax) c1_nxt = c1_r + 1'b1;
          if (mode_nxt == ssf_pkg::ST_RECOVERING && tgt == ssf_pkg::ST_NOMINAL && c2_r != CntMax)
            c2_nxt = c2_r + 1'b1;
          mode_nxt = tgt;
          chg = 1'b1;
        end
        prev_nxt = it.time_ms;
      end
      ssf_pkg::CMD_CHECK: begin
        if (it.cmd_is_estop) ok = 1'b1;
        else if (lock_r || mode_r == ssf_pkg::ST_FATAL) ok = 1'b0;
        else if (mode_r == ssf_pkg::ST_HOLD)
          ok = it.cmd_priority == 2'd3 && it.cmd_source <= 3'd5
             && cfg.src_mask[it.cmd_source];
        else if (mode_r == ssf_pkg::ST_STARTUP || mode_r == ssf_pkg::ST_RECOVERING)
          ok = it.cmd_priority == 2'd3;
        else if (mode_r == ssf_pkg::ST_DEGRADED && !cfg.nad && !it.cmd_priority[1]) ok = 1'b0;
        else if (it.cmd_source == 3'd2 && (act_r & (ssf_pkg::F_IMU_TO | ssf_pkg::F_IMU_BUS)) != '0)
          ok = 1'b0;
        else if (it.cmd_source == 3'd1 && act_r[1]) ok = 1'b0;
        else ok = 1'b1;
        acc = ok;
      end
      ssf_pkg::CMD_ESTOP: begin
        stop = 1'b1;
        act_nxt = act_r | it.estop_cause;
        lat_nxt = lat_r | it.estop_cause;
        if (c0_r != CntMax) c0_nxt = c0_r + 1'b1;
        if (mode_r != ssf_pkg::ST_HOLD) begin
          mode_nxt = ssf_pkg::ST_HOLD; chg = 1'b1;
        end
      end
      ssf_pkg::CMD_RECOVER: begin
        if ((mode_r == ssf_pkg::ST_HOLD || mode_r == ssf_pkg::ST_DEGRADED)
            && (act_r & ssf_pkg::HARD_MASK) == '0) begin
          act_nxt = act_r & ~ssf_pkg::SOFT_MASK;
          rstart_nxt = it.time_ms;
          mode_nxt = ssf_pkg::ST_RECOVERING;
          chg = 1'b1;
          acc = 1'b1;
        end
      end
      ssf_pkg::CMD_CLEAR: lat_nxt = '0;
      ssf_pkg::CMD_WDOG:  wpend_nxt = 1'b1;
      ssf_pkg::CMD_DROP:  if (drops_r != 16'hFFFF) drops_nxt = drops_r + 16'd1;
      default: begin
        lock_nxt = it.lock_value;
        stop = it.lock_value;
      end
    endcase
    res_nxt.accepted       = acc;
    res_nxt.safety_state   = mode_nxt;
    res_nxt.active_faults  = act_nxt;
    res_nxt.latched_faults = lat_nxt;
    res_nxt.imu_ok         = health_nxt[0];
    res_nxt.emg_ok         = health_nxt[1];
    res_nxt.stop_motion    = stop;
    res_nxt.state_changed  = chg;
    res_nxt.lowest_heap    = heapmin_nxt;
    res_nxt.estop_total    = 16'(c0_nxt);
    res_nxt.degraded_total = 16'(c1_nxt);
    res_nxt.recovery_total = 16'(c2_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ssf_pkg::ST_NOMINAL; act_r <= '0; lat_r <= '0; prev_r <= '0;
      rstart_r <= '0; win_r <= '0; heapmin_r <= '1; drops_r <= '0; wpend_r <= 1'b0;
      lock_r <= 1'b0; health_r <= 2'b11; c0_r <= '0; c1_r <= '0; c2_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (take) begin
        mode_r <= mode_nxt; act_r <= act_nxt; lat_r <= lat_nxt; prev_r <= prev_nxt;
        rstart_r <= rstart_nxt; win_r <= win_nxt; heapmin_r <= heapmin_nxt;
        drops_r <= drops_nxt; wpend_r <= wpend_nxt; lock_r <= lock_nxt;
        health_r <= health_nxt; c0_r <= c0_nxt; c1_r <= c1_nxt; c2_r <= c2_nxt;
      end
      if (q_ready) ovalid_r <= q_valid;
    end
    if (take) res_r <= res_nxt;
  end

  assign o_valid = ovalid_r;
  assign o_res   = res_r;

  a_latched_covers: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_item.command != ssf_pkg::CMD_CLEAR |=> (res_r.latched_faults & $past(lat_r)) == $past(lat_r))
    else $error("latched faults lost without clear");
  a_stop_estop: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_item.command == ssf_pkg::CMD_ESTOP |=> res_r.stop_motion && mode_r == ssf_pkg::ST_HOLD)
    else $error("estop did not stop and hold");
  a_no_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != ssf_pkg::ST_FATAL && mode_r != ssf_pkg::ST_STARTUP)
    else $error("unreachable state entered");
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(res_r))
    else $error("result changed while stalled");
endmodule

// ===== rtl/safety_supervisor_fsm_unit.sv =====
// safety_supervisor_fsm_unit: top level of the safety supervisor
// depends on ssf_pkg, ssf_front, ssf_queue, ssf_back
// One event item in, one result item out. Throughput is one item per clock while out_tready
// is high; back-pressure stalls the pipeline. A result passes the front register, then the
// queue entry, then the result register in the back part. The state update in ssf_back sets
// the rate. Registers on the apb port sit at byte address 4*i; write them only while no
// item is in flight.
module safety_supervisor_fsm_unit #(
  parameter int DROP_WINDOW_MS = 5000,
  parameter int COUNTER_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0], time_ms[34:3], imu_flags[38:35], imu_sample_ms[70:39], emg_flags[74:71],
  // emg_sample_ms[106:75], free_heap[138:107], cmd_is_estop[139], cmd_priority[141:140],
  // cmd_source[144:142], estop_cause[157:145], lock_value[158], zero pad to 160
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted[0], safety_state[3:1], active_faults[16:4], latched_faults[29:17], imu_ok[30],
  // emg_ok[31], stop_motion[32], state_changed[33], lowest_heap[65:34],
  // estop_total[81:66], degraded_total[97:82], recovery_total[113:98], pad to 120
  output logic [119:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  ssf_pkg::cfg_t    cfg_r;
  ssf_pkg::item_t   f_item, q_item;
  ssf_pkg::result_t res;
  logic             f_valid, f_ready, q_valid, q_ready;
  logic [2:0]       ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  // configuration registers, reset to documented defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wdog_forces <= 1'b1;
      cfg_r.qlimit      <= 16'd10;
      cfg_r.nad         <= 1'b0;
      cfg_r.src_mask    <= 6'd1;
      cfg_r.imu_stale   <= 16'd100;
      cfg_r.emg_stale   <= 16'd200;
      cfg_r.heap_floor  <= 32'd16384;
      cfg_r.settle      <= 16'd1000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (ridx)
        ssf_pkg::REG_WDOG:   cfg_r.wdog_forces <= cfg_pwdata[0];
        ssf_pkg::REG_QLIMIT: cfg_r.qlimit      <= cfg_pwdata[15:0];
        ssf_pkg::REG_NAD:    cfg_r.nad         <= cfg_pwdata[0];
        ssf_pkg::REG_SRC:    cfg_r.src_mask    <= cfg_pwdata[5:0];
        ssf_pkg::REG_IMU:    cfg_r.imu_stale   <= cfg_pwdata[15:0];
        ssf_pkg::REG_EMG:    cfg_r.emg_stale   <= cfg_pwdata[15:0];
        ssf_pkg::REG_HEAP:   cfg_r.heap_floor  <= cfg_pwdata;
        default:             cfg_r.settle      <= cfg_pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      ssf_pkg::REG_WDOG:   cfg_prdata = {31'd0, cfg_r.wdog_forces};
      ssf_pkg::REG_QLIMIT: cfg_prdata = {16'd0, cfg_r.qlimit};
      ssf_pkg::REG_NAD:    cfg_prdata = {31'd0, cfg_r.nad};
      ssf_pkg::REG_SRC:    cfg_prdata = {26'd0, cfg_r.src_mask};
      ssf_pkg::REG_IMU:    cfg_prdata = {16'd0, cfg_r.imu_stale};
      ssf_pkg::REG_EMG:    cfg_prdata = {16'd0, cfg_r.emg_stale};
      ssf_pkg::REG_HEAP:   cfg_prdata = cfg_r.heap_floor;
      default:             cfg_prdata = {16'd0, cfg_r.settle};
    endcase
  end

  // front: register the item and precompute sensor age and heap compares
  ssf_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .command(in_tdata[2:0]), .time_ms(in_tdata[34:3]), .imu_flags(in_tdata[38:35]),
    .imu_sample_ms(in_tdata[70:39]), .emg_flags(in_tdata[74:71]),
    .emg_sample_ms(in_tdata[106:75]), .free_heap(in_tdata[138:107]),
    .cmd_is_estop(in_tdata[139]), .cmd_priority(in_tdata[141:140]),
    .cmd_source(in_tdata[144:142]), .estop_cause(in_tdata[157:145]),
    .lock_value(in_tdata[158]), .cfg(cfg_r),
    .f_valid, .f_ready, .f_item
  );

  ssf_queue u_queue (
    .clk, .rst_n, .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
    .r_valid(q_valid), .r_ready(q_ready), .r_item(q_item)
  );

  // back: the supervisor state machine and counters
  ssf_back #(.DROP_WINDOW_MS(DROP_WINDOW_MS), .COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_ready, .q_item,
    .o_valid(out_tvalid), .o_ready(out_tready), .o_res(res)
  );

  assign out_tdata = {6'd0, res.recovery_total, res.degraded_total, res.estop_total,
                      res.lowest_heap, res.state_changed, res.stop_motion, res.emg_ok,
                      res.imu_ok, res.latched_faults, res.active_faults,
                      res.safety_state, res.accepted};
endmodule
